// File: src/nearest_point_search_assert.svh
// Assertion shorthands for the point search block, clocked on i_clk and
// disabled while i_rst_n is low.
`ifndef NEAREST_POINT_SEARCH_ASSERT_SVH
`define NEAREST_POINT_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 33;
    localparam int OUT_IDX_W  = 6;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // One point handed from the cell chain to the distance unit.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic [IDX_W-1:0] index;
        t_point           pt;
    } t_scan_req;

    // Keep the low bits of a list position for the result field.
    function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

// File: src/nps_cell.sv
`timescale 1ns / 1ps

module nps_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_load,
    input  nps_pkg::t_point i_load_pt,
    input  nps_pkg::t_point i_next_pt,
    output nps_pkg::t_point o_pt
);
    import nps_pkg::*;

    t_point r_pt;
    t_point n_pt;

    always_comb begin
        n_pt = r_pt;
        if (i_shift) begin
            n_pt = i_next_pt;
        end else if (i_load) begin
            n_pt = i_load_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
    end

    assign o_pt = r_pt;

endmodule

// File: src/nps_dist.sv
`timescale 1ns / 1ps

module nps_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nps_pkg::t_scan_req          i_req,
    input  nps_pkg::t_point             i_query,
    output logic [nps_pkg::IDX_W-1:0]   o_best_index,
    output logic [nps_pkg::DIST_W-1:0]  o_best_dist,
    output logic                        o_busy
);
    import nps_pkg::*;

    // Stage A: per-axis absolute difference.
    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic [COORD_W:0]        w_dx_mag;
    logic [COORD_W:0]        w_dy_mag;

    logic               r_a_valid;
    logic               r_a_first;
    logic [IDX_W-1:0]   r_a_index;
    logic [COORD_W-1:0] r_a_dx;
    logic [COORD_W-1:0] r_a_dy;

    // Stage B: per-axis squares.
    logic [SQ_W-1:0]    n_b_sqx;
    logic [SQ_W-1:0]    n_b_sqy;
    logic               r_b_valid;
    logic               r_b_first;
    logic [IDX_W-1:0]   r_b_index;
    logic [SQ_W-1:0]    r_b_sqx;
    logic [SQ_W-1:0]    r_b_sqy;

    // Stage C: sum and running minimum.
    logic [DIST_W-1:0]  w_sum;
    logic               w_take;
    logic [IDX_W-1:0]   r_best_index;
    logic [DIST_W-1:0]  r_best_dist;

    assign w_dx = {i_req.pt.x[COORD_W-1], i_req.pt.x} - {i_query.x[COORD_W-1], i_query.x};
    assign w_dy = {i_req.pt.y[COORD_W-1], i_req.pt.y} - {i_query.y[COORD_W-1], i_query.y};
    assign w_dx_mag = w_dx[COORD_W] ? (COORD_W+1)'(-w_dx) : (COORD_W+1)'(w_dx);
    assign w_dy_mag = w_dy[COORD_W] ? (COORD_W+1)'(-w_dy) : (COORD_W+1)'(w_dy);

    assign n_b_sqx = SQ_W'(r_a_dx) * SQ_W'(r_a_dx);
    assign n_b_sqy = SQ_W'(r_a_dy) * SQ_W'(r_a_dy);

    assign w_sum  = DIST_W'(r_b_sqx) + DIST_W'(r_b_sqy);
    // Strict less-than: the earliest point keeps a tie.
    assign w_take = r_b_valid && (r_b_first || (w_sum < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_req.valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_first <= i_req.first;
        r_a_index <= i_req.index;
        r_a_dx    <= w_dx_mag[COORD_W-1:0];
        r_a_dy    <= w_dy_mag[COORD_W-1:0];
        r_b_first <= r_a_first;
        r_b_index <= r_a_index;
        r_b_sqx   <= n_b_sqx;
        r_b_sqy   <= n_b_sqy;
        if (w_take) begin
            r_best_index <= r_b_index;
            r_best_dist  <= w_sum;
        end
    end

    assign o_best_index = r_best_index;
    assign o_best_dist  = r_best_dist;
    assign o_busy       = r_a_valid || r_b_valid;

endmodule

// File: src/nearest_point_search.sv
`timescale 1ns / 1ps
`include "nearest_point_search_assert.svh"

// Nearest-point search over a list of up to MAX_POINTS signed Q11.4 points,
// held one point per cell in a chain. Append and clear requests complete
// in the idle state. A query on a non-empty list rotates the whole chain
// once, feeding the head cell into a three-stage distance and minimum unit,
// then waits until that unit is empty and the output register is free, and
// registers the result. A query on an empty list goes straight to the drain
// state and returns none_found. The request port is ready only between
// operations; a finished result waits in the output register until it is taken.
module nearest_point_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_operation,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [nps_pkg::OUT_IDX_W-1:0]      o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]         o_nearest_distance_sq,
    output logic                               o_none_found
);
    import nps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_POINTS - 1);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_step, n_step;
    logic                 r_empty, n_empty;
    t_point               r_query, n_query;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_IDX_W-1:0] r_out_index, n_out_index;
    logic [DIST_W-1:0]    r_out_dist, n_out_dist;
    logic                 r_out_none, n_out_none;

    logic                 w_accept;
    logic                 w_append;
    logic                 w_shift;
    t_point               w_new_pt;
    t_point               w_cell_pt [MAX_POINTS];
    t_scan_req            w_req;
    logic [IDX_W-1:0]     w_best_index;
    logic [DIST_W-1:0]    w_best_dist;
    logic                 w_dist_busy;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_shift  = (r_state == S_SCAN);
    assign w_new_pt = '{x: i_coord_x, y: i_coord_y};

    // Rotate toward the head; after one full rotation the list is back in order.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        localparam int NEXT = (i + 1) % MAX_POINTS;
        nps_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_shift),
            .i_load    (w_append && (r_count == CNT_W'(i))),
            .i_load_pt (w_new_pt),
            .i_next_pt (w_cell_pt[NEXT]),
            .o_pt      (w_cell_pt[i])
        );
    end

    always_comb begin
        w_req.valid = w_shift && (CNT_W'(r_step) < r_count);
        w_req.first = (r_step == '0);
        w_req.index = r_step;
        w_req.pt    = w_cell_pt[0];
    end

    nps_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_query      (r_query),
        .o_best_index (w_best_index),
        .o_best_dist  (w_best_dist),
        .o_busy       (w_dist_busy)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_empty     = r_empty;
        n_query     = r_query;
        n_out_valid = r_out_valid && !i_ready;
        n_out_index = r_out_index;
        n_out_dist  = r_out_dist;
        n_out_none  = r_out_none;
        w_append    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        OP_APPEND: begin
                            if (r_count < CNT_W'(MAX_POINTS)) begin
                                w_append = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_QUERY: begin
                            n_query = w_new_pt;
                            n_step  = '0;
                            n_empty = (r_count == '0);
                            n_state = (r_count == '0) ? S_DRAIN : S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Hold until the unit is empty and the output register is free.
                if (!w_dist_busy && (!r_out_valid || i_ready)) begin
                    n_out_valid = 1'b1;
                    n_out_none  = r_empty;
                    n_out_index = r_empty ? '0 : out_index(w_best_index);
                    n_out_dist  = r_empty ? '0 : w_best_dist;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_empty     <= n_empty;
        r_query     <= n_query;
        r_out_index <= n_out_index;
        r_out_dist  <= n_out_dist;
        r_out_none  <= n_out_none;
    end

    assign o_valid               = r_out_valid;
    assign o_nearest_index       = r_out_index;
    assign o_nearest_distance_sq = r_out_dist;
    assign o_none_found          = r_out_none;

    `NPS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_POINTS), "point count over limit")
    `NPS_ASSERT_NEXT(a_scan_ends, (r_state == S_SCAN) && (r_step == LAST_STEP), r_state == S_DRAIN, "scan did not end after full rotation")
    `NPS_ASSERT_NEXT(a_empty_query, w_accept && (i_operation == OP_QUERY) && (r_count == '0), (r_state == S_DRAIN) && r_empty, "empty query not sent to drain")
    `NPS_ASSERT_SAME(a_none_zero, o_valid && o_none_found, (o_nearest_index == '0) && (o_nearest_distance_sq == '0), "none_found result not zero")

endmodule

// File: test/nearest_point_search_tb.sv
`timescale 1ns / 1ps

module nearest_point_search_tb;
    import nps_pkg::*;

    localparam logic [1:0]                OP_UNUSED     = 2'd3;
    localparam logic signed [COORD_W-1:0] C_MIN         = 16'sh8000;
    localparam logic signed [COORD_W-1:0] C_MAX         = 16'sh7FFF;
    localparam int                        DIRECTED_ROWS = 25;
    localparam int                        RANDOM_ITEMS  = 300;
    localparam int                        LONG_HOLD     = 400;
    localparam int                        STALL_LIMIT   = 3000;
    localparam int                        DRAIN_CYCLES  = MAX_POINTS + 16;
    localparam int                        REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic [DIST_W-1:0]    dist_sq;
        logic                 none_found;
    } t_nearest_result;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        int                        reps;
        bit                        typed;
        t_nearest_result           want;
    } t_directed_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [1:0]                  i_operation;
    logic signed [COORD_W-1:0]   i_coord_x;
    logic signed [COORD_W-1:0]   i_coord_y;
    logic                        o_valid;
    logic                        i_ready;
    logic [OUT_IDX_W-1:0]        o_nearest_index;
    logic [DIST_W-1:0]           o_nearest_distance_sq;
    logic                        o_none_found;

    // Predicted point list
    logic signed [COORD_W-1:0]   stored_x [MAX_POINTS];
    logic signed [COORD_W-1:0]   stored_y [MAX_POINTS];
    int                          stored_count;
    t_nearest_result             nearest_expected_q [$];

    t_directed_row               directed_rows [DIRECTED_ROWS];
    int                          failures;
    int                          random_sent;
    int                          sender_idle_pct;
    int                          receiver_stall_pct;
    bit                          ready_hold_request;
    bit                          pressure_done;
    int                          stalled_cycles;

    nearest_point_search i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_operation           (i_operation),
        .i_coord_x             (i_coord_x),
        .i_coord_y             (i_coord_y),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_nearest_index       (o_nearest_index),
        .o_nearest_distance_sq (o_nearest_distance_sq),
        .o_none_found          (o_none_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_nearest_result find_nearest(input logic signed [COORD_W-1:0] qx,
                                                     input logic signed [COORD_W-1:0] qy);
        t_nearest_result best;
        longint          dx;
        longint          dy;
        longint          cand_dist;
        longint          best_dist;
        best      = '0;
        best_dist = 0;
        best.none_found = (stored_count == 0);
        for (int i = 0; i < stored_count; i++) begin
            dx        = longint'(stored_x[i]) - longint'(qx);
            dy        = longint'(stored_y[i]) - longint'(qy);
            cand_dist = dx * dx + dy * dy;
            // strict less-than: the earliest of equal points wins
            if (i == 0 || cand_dist < best_dist) begin
                best_dist     = cand_dist;
                best.index    = OUT_IDX_W'(i);
                best.dist_sq  = DIST_W'(best_dist);
            end
        end
        return best;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return COORD_W'($urandom);
        if (pick < 85)
            return $signed(COORD_W'($urandom_range(511))) - 16'sd256;
        case ($urandom_range(3))
            0: return C_MIN;
            1: return C_MAX;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Present one request, wait for it to be taken, then update the predicted list.
    task automatic send_request(input logic [1:0] op,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input bit typed, input t_nearest_result want);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_coord_x   <= x;
        i_coord_y   <= y;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        case (op)
            OP_APPEND: begin
                if (stored_count < MAX_POINTS) begin
                    stored_x[stored_count] = x;
                    stored_y[stored_count] = y;
                    stored_count++;
                end
            end
            OP_CLEAR: stored_count = 0;
            OP_QUERY: nearest_expected_q = {nearest_expected_q,
                                            typed ? want : find_nearest(x, y)};
            default: ;
        endcase
    endtask

    task automatic send_random(input logic [1:0] op,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        case (random_sent * 4 / RANDOM_ITEMS)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
        endcase
        // hold the result port once so the block backs up into its request port
        if (!pressure_done && random_sent >= 20) begin
            pressure_done      = 1'b1;
            ready_hold_request = 1'b1;
        end
        if (op != OP_UNUSED && !(op == OP_APPEND && stored_count >= MAX_POINTS))
            random_sent++;
        send_request(op, x, y, 1'b0, '0);
    endtask

    task automatic send_near_query();
        int pick;
        if (stored_count == 0) begin
            send_random(OP_QUERY, rand_coord(), rand_coord());
        end else begin
            pick = $urandom_range(stored_count - 1);
            send_random(OP_QUERY,
                        stored_x[pick] + COORD_W'($urandom_range(6)) - 16'sd3,
                        stored_y[pick] + COORD_W'($urandom_range(6)) - 16'sd3);
        end
    endtask

    // Result port: random stalls, one long hold on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_request) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                ready_hold_request = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_nearest_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (nearest_expected_q.size() == 0) begin
                note_failure($sformatf("result with no query pending: index %0d dist %0d none %0b",
                                       o_nearest_index, o_nearest_distance_sq, o_none_found));
            end else begin
                want = nearest_expected_q.pop_front();
                if (want.index !== o_nearest_index || want.dist_sq !== o_nearest_distance_sq ||
                    want.none_found !== o_none_found)
                    note_failure($sformatf(
                        "expected index %0d dist %0d none %0b, got index %0d dist %0d none %0b",
                        want.index, want.dist_sq, want.none_found,
                        o_nearest_index, o_nearest_distance_sq, o_none_found));
            end
        end
    end

    initial begin
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int kind;
        int n;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_operation        = OP_APPEND;
        i_coord_x          = '0;
        i_coord_y          = '0;
        failures           = 0;
        random_sent        = 0;
        stored_count       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        ready_hold_request = 1'b0;
        pressure_done      = 1'b0;

        directed_rows = '{
            '{OP_QUERY,  16'sd0,     16'sd0,     1,  1'b1, '{6'd0,  33'd0,          1'b1}},
            '{OP_UNUSED, C_MAX,      C_MIN,      1,  1'b0, '0},
            '{OP_QUERY,  C_MIN,      C_MAX,      1,  1'b1, '{6'd0,  33'd0,          1'b1}},
            '{OP_APPEND, C_MIN,      C_MIN,      1,  1'b0, '0},
            '{OP_QUERY,  C_MAX,      C_MAX,      1,  1'b1, '{6'd0,  33'd8589672450, 1'b0}},
            '{OP_APPEND, C_MAX,      C_MAX,      1,  1'b0, '0},
            '{OP_QUERY,  C_MAX,      C_MAX,      1,  1'b1, '{6'd1,  33'd0,          1'b0}},
            '{OP_QUERY,  C_MIN,      C_MAX,      1,  1'b1, '{6'd0,  33'd4294836225, 1'b0}},
            '{OP_APPEND, 16'sd0,     16'sd0,     1,  1'b0, '0},
            '{OP_APPEND, 16'sd0,     16'sd0,     1,  1'b0, '0},
            '{OP_QUERY,  16'sd0,     16'sd0,     1,  1'b1, '{6'd2,  33'd0,          1'b0}},
            '{OP_QUERY,  16'sd16,    -16'sd16,   1,  1'b1, '{6'd2,  33'd512,        1'b0}},
            '{OP_APPEND, 16'sh5555,  16'shAAAA,  1,  1'b0, '0},
            '{OP_QUERY,  16'shAAAA,  16'sh5555,  1,  1'b0, '0},
            '{OP_CLEAR,  16'sd0,     16'sd0,     1,  1'b0, '0},
            '{OP_QUERY,  16'sd1,     16'sd1,     1,  1'b1, '{6'd0,  33'd0,          1'b1}},
            '{OP_APPEND, -16'sd1,    -16'sd1,    1,  1'b0, '0},
            '{OP_QUERY,  16'sd0,     16'sd0,     1,  1'b1, '{6'd0,  33'd2,          1'b0}},
            '{OP_UNUSED, 16'sd0,     16'sd0,     1,  1'b0, '0},
            '{OP_QUERY,  C_MAX,      C_MIN,      1,  1'b0, '0},
            '{OP_CLEAR,  16'sd0,     16'sd0,     1,  1'b0, '0},
            // fill past the end: the last two appends must be dropped
            '{OP_APPEND, 16'sd0,     16'sd0,     66, 1'b0, '0},
            '{OP_QUERY,  16'sd100,   -16'sd100,  1,  1'b1, '{6'd63, 33'd2738,       1'b0}},
            '{OP_QUERY,  16'sd0,     16'sd0,     1,  1'b1, '{6'd0,  33'd0,          1'b0}},
            '{OP_CLEAR,  16'sd0,     16'sd0,     1,  1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_request(directed_rows[r].op,
                             directed_rows[r].x + COORD_W'(k),
                             directed_rows[r].y - COORD_W'(k),
                             directed_rows[r].typed, directed_rows[r].want);

        while (random_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                n = $urandom_range(6, 1);
                repeat (n) send_random(OP_APPEND, rand_coord(), rand_coord());
                n = $urandom_range(3, 1);
                repeat (n) begin
                    if ($urandom_range(1))
                        send_near_query();
                    else
                        send_random(OP_QUERY, rand_coord(), rand_coord());
                end
            end else if (kind < 65) begin
                send_random(OP_QUERY, rand_coord(), rand_coord());
            end else if (kind < 73) begin
                send_random(OP_CLEAR, rand_coord(), rand_coord());
            end else if (kind < 75) begin
                while (stored_count < MAX_POINTS)
                    send_random(OP_APPEND, rand_coord(), rand_coord());
                n = $urandom_range(3, 1);
                repeat (n) send_random(OP_APPEND, rand_coord(), rand_coord());
                send_near_query();
            end else if (kind < 82) begin
                send_random(OP_UNUSED, rand_coord(), rand_coord());
            end else begin
                send_near_query();
            end
        end
        i_valid <= 1'b0;

        while (nearest_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/nps_pkg.sv
src/nps_cell.sv
src/nps_dist.sv
src/nearest_point_search.sv
test/nearest_point_search_tb.sv
